// File: rtl/rfs_pkg.sv
`timescale 1ns / 1ps

package rfs_pkg;

	// field widths fixed by the bus and the register file
	localparam int WORD_W     = 16;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int MODE_W     = 2;
	localparam int STEP_W     = 4;

	// controller modes
	localparam logic [MODE_W-1:0] MODE_DCS16 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DCS8  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REG   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ALT   = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// register reset values
	localparam logic [MODE_W-1:0]     RST_MODE   = MODE_DCS8;
	localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;

	// input actions
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	// header lengths
	localparam logic [STEP_W-1:0] HDR_LEN_DCS = 4'd11;
	localparam logic [STEP_W-1:0] HDR_LEN_REG = 4'd13;

	// dcs commands
	localparam logic [WORD_W-1:0] DCS_COL_ADDR = 16'h002A;
	localparam logic [WORD_W-1:0] DCS_PAGE_ADDR = 16'h002B;
	localparam logic [WORD_W-1:0] DCS_MEM_WRITE = 16'h002C;

	// register-indexed window commands
	localparam logic [WORD_W-1:0] REG_HSTART = 16'h0050;
	localparam logic [WORD_W-1:0] REG_HEND   = 16'h0051;
	localparam logic [WORD_W-1:0] REG_VSTART = 16'h0052;
	localparam logic [WORD_W-1:0] REG_VEND   = 16'h0053;
	localparam logic [WORD_W-1:0] REG_GRAM_X = 16'h0020;
	localparam logic [WORD_W-1:0] REG_GRAM_Y = 16'h0021;
	localparam logic [WORD_W-1:0] REG_GRAM_WR = 16'h0022;

	// one panel bus word
	typedef struct packed {
		logic              is_command;
		logic [WORD_W-1:0] word;
	} bus_word_t;

endpackage

// File: rtl/rfs_hdr_gen.sv
`timescale 1ns / 1ps

module rfs_hdr_gen #(
	parameter int COORD_W = 10
) (
	input  logic [rfs_pkg::MODE_W-1:0] mode,
	input  logic [rfs_pkg::STEP_W-1:0] step,
	input  logic [COORD_W-1:0]         win_left,
	input  logic [COORD_W-1:0]         win_top,
	input  logic [COORD_W-1:0]         win_right,
	input  logic [COORD_W-1:0]         win_bottom,
	output rfs_pkg::bus_word_t         hdr
);

	localparam int PAD_W = rfs_pkg::WORD_W - COORD_W;

	logic [rfs_pkg::WORD_W-1:0] left_w, top_w, right_w, bottom_w;
	rfs_pkg::bus_word_t         dcs, regw;

	// coordinates widened to a bus word
	assign left_w   = {{PAD_W{1'b0}}, win_left};
	assign top_w    = {{PAD_W{1'b0}}, win_top};
	assign right_w  = {{PAD_W{1'b0}}, win_right};
	assign bottom_w = {{PAD_W{1'b0}}, win_bottom};

	// dcs window header, coordinates as high and low bytes
	always_comb begin
		dcs.is_command = 1'b0;
		dcs.word       = '0;
		unique case (step)
			4'd0: begin
				dcs.is_command = 1'b1;
				dcs.word       = rfs_pkg::DCS_COL_ADDR;
			end
			4'd1: dcs.word = {8'h00, left_w[15:8]};
			4'd2: dcs.word = {8'h00, left_w[7:0]};
			4'd3: dcs.word = {8'h00, right_w[15:8]};
			4'd4: dcs.word = {8'h00, right_w[7:0]};
			4'd5: begin
				dcs.is_command = 1'b1;
				dcs.word       = rfs_pkg::DCS_PAGE_ADDR;
			end
			4'd6: dcs.word = {8'h00, top_w[15:8]};
			4'd7: dcs.word = {8'h00, top_w[7:0]};
			4'd8: dcs.word = {8'h00, bottom_w[15:8]};
			4'd9: dcs.word = {8'h00, bottom_w[7:0]};
			default: begin
				dcs.is_command = 1'b1;
				dcs.word       = rfs_pkg::DCS_MEM_WRITE;
			end
		endcase
	end

	// register-indexed window header, index then value
	always_comb begin
		regw.is_command = 1'b0;
		regw.word       = '0;
		unique case (step)
			4'd0: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_HSTART;
			end
			4'd1: regw.word = left_w;
			4'd2: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_HEND;
			end
			4'd3: regw.word = right_w;
			4'd4: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_VSTART;
			end
			4'd5: regw.word = top_w;
			4'd6: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_VEND;
			end
			4'd7: regw.word = bottom_w;
			4'd8: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_GRAM_X;
			end
			4'd9: regw.word = left_w;
			4'd10: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_GRAM_Y;
			end
			4'd11: regw.word = top_w;
			default: begin
				regw.is_command = 1'b1;
				regw.word       = rfs_pkg::REG_GRAM_WR;
			end
		endcase
	end

	assign hdr = (mode == rfs_pkg::MODE_REG) ? regw : dcs;

endmodule

// File: rtl/rect_fill_bus_sequencer.sv
`timescale 1ns / 1ps

// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_ready   | action, rect_x, rect_y, rect_w, rect_h,
//          |           |                       | pixel_color
// out      | output    | out_valid / out_ready | is_command, bus_word, fill_done
// cfg      | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// one word per cycle: a start or advance word is taken every cycle while the
// output register is empty or being drained in the same cycle.
// an advance word's result is registered in the output register in the cycle after it
// is taken; a start word and an advance while idle give no result.
// arst_n idles the fill state, empties the output register and loads the
// register defaults.
// a stall on out only holds in_ready low while the output register is full.

module rect_fill_bus_sequencer #(
	parameter int PANEL_DIM_MAX = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [15:0]                           rect_x,
	input  logic [15:0]                           rect_y,
	input  logic [15:0]                           rect_w,
	input  logic [15:0]                           rect_h,
	input  logic [15:0]                           pixel_color,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  is_command,
	output logic [rfs_pkg::WORD_W-1:0]            bus_word,
	output logic                                  fill_done,
	input  logic                                  cfg_we,
	input  logic [rfs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rfs_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int COORD_W = $clog2(PANEL_DIM_MAX);
	localparam int DIM_W   = $clog2(PANEL_DIM_MAX + 1);

	// config registers
	logic [rfs_pkg::MODE_W-1:0]     mode_q;
	logic [rfs_pkg::CFG_DATA_W-1:0] width_q, height_q;

	// fill state
	logic                       fill_active_q, fill_active_d;
	logic [rfs_pkg::STEP_W-1:0] header_step_q, header_step_d;
	logic                       low_byte_next_q, low_byte_next_d;
	logic [COORD_W-1:0]         win_left_q, win_top_q, win_right_q, win_bottom_q;
	logic [COORD_W-1:0]         col_last_q, col_cnt_q, row_cnt_q;
	logic [COORD_W-1:0]         col_cnt_d, row_cnt_d;
	logic [15:0]                colour_q;

	// output register
	logic                 out_valid_q;
	rfs_pkg::bus_word_t   out_word_q;
	logic                 out_done_q;

	logic                       in_fire, load_win;
	logic [rfs_pkg::MODE_W-1:0] eff_mode;
	logic [rfs_pkg::STEP_W-1:0] hdr_len;
	logic [31:0]                pw32, ph32;
	logic [DIM_W-1:0]           pw, ph, avail_w, avail_h, w_clip, h_clip;
	logic                       drop;
	logic [COORD_W-1:0]         new_right, new_bottom, new_w_m1, new_h_m1;
	rfs_pkg::bus_word_t         hdr, res_word;
	logic                       res_valid, res_done;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// mode 3 runs as mode 0
	assign eff_mode = (mode_q == rfs_pkg::MODE_ALT) ? rfs_pkg::MODE_DCS16 : mode_q;
	assign hdr_len  = (eff_mode == rfs_pkg::MODE_REG) ? rfs_pkg::HDR_LEN_REG
	                                                  : rfs_pkg::HDR_LEN_DCS;

	// effective panel size, clamped to 1..PANEL_DIM_MAX
	always_comb begin
		pw32 = 32'(width_q);
		ph32 = 32'(height_q);
		if (pw32 == 32'd0)
			pw32 = 32'd1;
		else if (pw32 > 32'(PANEL_DIM_MAX))
			pw32 = 32'(PANEL_DIM_MAX);
		if (ph32 == 32'd0)
			ph32 = 32'd1;
		else if (ph32 > 32'(PANEL_DIM_MAX))
			ph32 = 32'(PANEL_DIM_MAX);
	end
	assign pw = pw32[DIM_W-1:0];
	assign ph = ph32[DIM_W-1:0];

	// rectangle reject and clip
	assign drop = (rect_w == 16'd0) || (rect_h == 16'd0)
	           || (32'(rect_x) >= 32'(pw)) || (32'(rect_y) >= 32'(ph));
	assign avail_w = pw - rect_x[DIM_W-1:0];
	assign avail_h = ph - rect_y[DIM_W-1:0];
	assign w_clip  = (32'(rect_w) > 32'(avail_w)) ? avail_w : rect_w[DIM_W-1:0];
	assign h_clip  = (32'(rect_h) > 32'(avail_h)) ? avail_h : rect_h[DIM_W-1:0];
	assign new_w_m1   = COORD_W'(w_clip - DIM_W'(1));
	assign new_h_m1   = COORD_W'(h_clip - DIM_W'(1));
	assign new_right  = rect_x[COORD_W-1:0] + new_w_m1;
	assign new_bottom = rect_y[COORD_W-1:0] + new_h_m1;

	rfs_hdr_gen #(
		.COORD_W (COORD_W)
	) u_hdr (
		.mode       (eff_mode),
		.step       (header_step_q),
		.win_left   (win_left_q),
		.win_top    (win_top_q),
		.win_right  (win_right_q),
		.win_bottom (win_bottom_q),
		.hdr        (hdr)
	);

	// next state and result for the accepted word
	always_comb begin
		fill_active_d   = fill_active_q;
		header_step_d   = header_step_q;
		low_byte_next_d = low_byte_next_q;
		col_cnt_d       = col_cnt_q;
		row_cnt_d       = row_cnt_q;
		load_win        = 1'b0;
		res_valid       = 1'b0;
		res_done        = 1'b0;
		res_word        = hdr;
		if (in_fire) begin
			if (action == rfs_pkg::ACT_START) begin
				fill_active_d   = !drop;
				header_step_d   = '0;
				low_byte_next_d = 1'b0;
				load_win        = !drop;
				col_cnt_d       = new_w_m1;
				row_cnt_d       = new_h_m1;
			end else if (fill_active_q) begin
				res_valid = 1'b1;
				if (header_step_q < hdr_len) begin
					header_step_d = header_step_q + 4'd1;
				end else begin
					res_word.is_command = 1'b0;
					if (eff_mode == rfs_pkg::MODE_DCS8 && !low_byte_next_q) begin
						// high byte, pixel not finished yet
						res_word.word   = {8'h00, colour_q[15:8]};
						low_byte_next_d = 1'b1;
					end else begin
						res_word.word   = (eff_mode == rfs_pkg::MODE_DCS8)
						                  ? {8'h00, colour_q[7:0]} : colour_q;
						low_byte_next_d = 1'b0;
						// step column, then row; last pixel ends the fill
						if (col_cnt_q == '0) begin
							if (row_cnt_q == '0) begin
								res_done      = 1'b1;
								fill_active_d = 1'b0;
								header_step_d = '0;
							end else begin
								col_cnt_d = col_last_q;
								row_cnt_d = row_cnt_q - COORD_W'(1);
							end
						end else begin
							col_cnt_d = col_cnt_q - COORD_W'(1);
						end
					end
				end
			end
		end
	end

	// control state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= rfs_pkg::RST_MODE;
			width_q         <= rfs_pkg::RST_WIDTH;
			height_q        <= rfs_pkg::RST_HEIGHT;
			fill_active_q   <= 1'b0;
			header_step_q   <= '0;
			low_byte_next_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rfs_pkg::CFG_MODE:   mode_q   <= cfg_data[rfs_pkg::MODE_W-1:0];
					rfs_pkg::CFG_WIDTH:  width_q  <= cfg_data;
					rfs_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			fill_active_q   <= fill_active_d;
			header_step_q   <= header_step_d;
			low_byte_next_q <= low_byte_next_d;
			if (in_fire)
				out_valid_q <= res_valid;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// window, colour, counters and output word
	always_ff @(posedge clk) begin
		col_cnt_q <= col_cnt_d;
		row_cnt_q <= row_cnt_d;
		if (load_win) begin
			win_left_q   <= rect_x[COORD_W-1:0];
			win_top_q    <= rect_y[COORD_W-1:0];
			win_right_q  <= new_right;
			win_bottom_q <= new_bottom;
			col_last_q   <= new_w_m1;
			colour_q     <= pixel_color;
		end
		if (in_fire && res_valid) begin
			out_word_q <= res_word;
			out_done_q <= res_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_command = out_word_q.is_command;
	assign bus_word   = out_word_q.word;
	assign fill_done  = out_done_q;

	// the last word of a fill is always pixel data
	a_done_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> !out_word_q.is_command)
		else $error("fill_done on a command word");

	// a finished fill leaves the block idle
	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && res_done) |=> !fill_active_q)
		else $error("fill still active after last word");

	// idle block always restarts its header from the first step
	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_active_q |-> (header_step_q == '0))
		else $error("header step nonzero while idle");

	// no low byte pending outside a fill
	a_idle_no_low: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_active_q |-> !low_byte_next_q)
		else $error("low byte pending while idle");

	// header step never runs past the longest header
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		header_step_q <= rfs_pkg::HDR_LEN_REG)
		else $error("header step out of range");

endmodule
